/* rtl/core/grbc_pkg.sv */
// Package for the gyro rate bias correction block: the job item type passed
// from the front to the back, register indexes, divider sizes and constants.
// Depends on nothing; every other file of the block uses it by scoped names.
package grbc_pkg;

    // Configuration register indexes.
    localparam logic [7:0] REG_CAL_SAMPLES  = 8'd0;
    localparam logic [7:0] REG_SENSOR_READY = 8'd1;

    localparam logic [15:0] CAL_SAMPLES_RESET = 16'd200;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Bias divider: 16-bit divisor, 24 quotient bits, one bit per cycle.
    // The dividend is known to be below den * 2**24, so it fits in 40 bits.
    localparam int DIV_DEN_W = 16;
    localparam int DIV_Q_W   = 24;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

    // Sensitivity 65.5 LSB per deg/s: rate = diff * 2 / 131.
    localparam int SENS_DEN  = 131;
    localparam int SENS_HALF = SENS_DEN / 2;

    // Division by 131 as a multiplication: 2**34 / 131 rounded up gives the
    // exact quotient for every numerator below 2**28.
    localparam int          SENS_SHIFT = 34;
    localparam logic [26:0] SENS_RECIP = 27'd131144040;

    // Work that the back has to carry out for one item.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_BIAS,
        OP_RATE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] raw;
        logic signed [31:0] sum;
        logic [15:0]        good;
        logic [15:0]        fail_count;
        logic               cal_done;
        logic               cal_ok;
    } job_t;

endpackage

/* rtl/core/grbc_front.sv */
// Front of the gyro rate bias correction block: configuration registers,
// calibration counters and the failure run; turns each item into a job.
// Depends on grbc_pkg.
module grbc_front (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write channel.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    // Input item channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic signed [15:0] s_raw_rate,
    input  logic              s_read_ok,
    // Job queue side.
    input  logic              q_full,
    output logic              q_push,
    output grbc_pkg::job_t    q_job
);

    logic [15:0]        cal_samples_reg;
    logic               sensor_ready_reg;
    logic signed [31:0] cal_sum_reg, cal_sum_next;
    logic [15:0]        cal_good_reg, cal_good_next;
    logic [15:0]        cal_attempts_reg, cal_attempts_next;
    logic [15:0]        fail_run_reg, fail_run_next;

    logic               accept;
    logic signed [31:0] sum_upd;
    logic [15:0]        good_upd;
    logic [16:0]        att_upd;
    logic               run_done;
    logic               bias_ok;
    logic               meas_fail;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept;

    // Classify the item, update the counters and build its job.
    always_comb begin
        sum_upd   = cal_sum_reg + (s_read_ok ? 32'(s_raw_rate) : 32'sd0);
        good_upd  = cal_good_reg + {15'd0, s_read_ok};
        att_upd   = {1'b0, cal_attempts_reg} + 17'd1;
        run_done  = att_upd >= {1'b0, cal_samples_reg};
        bias_ok   = (good_upd != 16'd0) && (good_upd >= {1'b0, cal_samples_reg[15:1]});
        meas_fail = !sensor_ready_reg || !s_read_ok;

        cal_sum_next      = cal_sum_reg;
        cal_good_next     = cal_good_reg;
        cal_attempts_next = cal_attempts_reg;
        fail_run_next     = fail_run_reg;

        q_job.op         = grbc_pkg::OP_NONE;
        q_job.raw        = s_raw_rate;
        q_job.sum        = sum_upd;
        q_job.good       = good_upd;
        q_job.cal_done   = 1'b0;
        q_job.cal_ok     = 1'b0;

        if (!s_command) begin
            // Calibration sample: a run ends once the attempts reach the target.
            if (run_done) begin
                q_job.cal_done    = 1'b1;
                q_job.cal_ok      = bias_ok;
                q_job.op          = bias_ok ? grbc_pkg::OP_BIAS : grbc_pkg::OP_NONE;
                cal_sum_next      = 32'sd0;
                cal_good_next     = 16'd0;
                cal_attempts_next = 16'd0;
            end else begin
                cal_sum_next      = sum_upd;
                cal_good_next     = good_upd;
                cal_attempts_next = att_upd[15:0];
            end
        end else begin
            // Measurement sample: failures count up and saturate; a good one clears the run and asks for a rate.
            if (meas_fail) begin
                if (fail_run_reg != 16'hFFFF) begin
                    fail_run_next = fail_run_reg + 16'd1;
                end
            end else begin
                fail_run_next = 16'd0;
                q_job.op      = grbc_pkg::OP_RATE;
            end
        end

        q_job.fail_count = fail_run_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples_reg  <= grbc_pkg::CAL_SAMPLES_RESET;
            sensor_ready_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == grbc_pkg::REG_CAL_SAMPLES) begin
                cal_samples_reg <= cfg_data;
            end else if (cfg_index == grbc_pkg::REG_SENSOR_READY) begin
                sensor_ready_reg <= cfg_data[0];
            end
        end
    end

    // Calibration and failure state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_sum_reg      <= 32'sd0;
            cal_good_reg     <= 16'd0;
            cal_attempts_reg <= 16'd0;
            fail_run_reg     <= 16'd0;
        end else if (accept) begin
            cal_sum_reg      <= cal_sum_next;
            cal_good_reg     <= cal_good_next;
            cal_attempts_reg <= cal_attempts_next;
            fail_run_reg     <= fail_run_next;
        end
    end

endmodule

/* rtl/core/grbc_queue.sv */
// Job queue between the front and the back of the gyro rate bias correction
// block; a small register FIFO. Depends on grbc_pkg.
module grbc_queue #(
    parameter int DEPTH = grbc_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  grbc_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output grbc_pkg::job_t pop_job,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    grbc_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign pop_job = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/grbc_div.sv */
// Unsigned restoring divider of the gyro rate bias correction block,
// one quotient bit per cycle. Depends on grbc_pkg for its sizes.
module grbc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [grbc_pkg::DIV_NUM_W-1:0]  num,
    input  logic [grbc_pkg::DIV_DEN_W-1:0]  den,
    output logic                            done,
    output logic [grbc_pkg::DIV_Q_W-1:0]    quot
);

    localparam int DEN_W = grbc_pkg::DIV_DEN_W;
    localparam int Q_W   = grbc_pkg::DIV_Q_W;
    localparam int NUM_W = grbc_pkg::DIV_NUM_W;
    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   sh_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    assign done = done_reg;
    assign quot = sh_reg;

    // One long-division step: shift in the next dividend bit and compare.
    always_comb begin
        trial     = {rem_reg, sh_reg[Q_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
    end

    // The high dividend bits start as the remainder, since they stay below den.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[NUM_W-1:Q_W];
            sh_reg  <= num[Q_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            sh_reg  <= {sh_reg[Q_W-2:0], fits};
        end
    end

endmodule

/* rtl/core/grbc_back.sv */
// Back of the gyro rate bias correction block: takes jobs from the queue,
// holds the bias, runs the bias division and the rate scaling and drives the
// result item. Depends on grbc_pkg and grbc_div.
module grbc_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Job queue side.
    input  logic                     q_empty,
    input  grbc_pkg::job_t           q_job,
    output logic                     q_pop,
    // Result item channel.
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [18:0]       m_rate_q8,
    output logic                     m_rate_valid,
    output logic [15:0]              m_fail_count,
    output logic                     m_cal_done,
    output logic                     m_cal_ok
);

    localparam int NUM_W  = grbc_pkg::DIV_NUM_W;
    localparam int DEN_W  = grbc_pkg::DIV_DEN_W;
    localparam int Q_W    = grbc_pkg::DIV_Q_W;
    localparam int RNUM_W = 27;
    localparam int PROD_W = 54;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PREP,
        B_WAIT,
        B_OUT
    } state_t;

    state_t             state_reg;
    grbc_pkg::job_t     job_reg;
    logic signed [23:0] bias_reg;
    logic signed [18:0] rate_reg;
    logic               neg_reg;
    logic [RNUM_W-1:0]  rate_num_reg;
    logic               m_valid_reg;

    logic [31:0]        sum_mag;
    logic [25:0]        diff;
    logic [25:0]        diff_mag;
    logic [RNUM_W-1:0]  rate_num;
    logic [PROD_W-1:0]  rate_prod;
    logic [18:0]        rate_mag;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_start;
    logic               div_done;
    logic [Q_W-1:0]     div_quot;
    logic [Q_W-1:0]     quot_signed;
    logic               out_load;

    assign q_pop   = (state_reg == B_IDLE) && !q_empty;
    assign m_valid = m_valid_reg;

    // Dividends in magnitude form; the sign is applied afterwards, which
    // gives rounding to nearest with ties away from zero.
    always_comb begin
        sum_mag  = job_reg.sum[31] ? (~job_reg.sum + 32'd1) : job_reg.sum;
        diff     = {{2{job_reg.raw[15]}}, job_reg.raw, 8'h00} - {{2{bias_reg[23]}}, bias_reg};
        diff_mag = diff[25] ? (~diff + 26'd1) : diff;
        // Bias: sum * 256 over the good count, with half the divisor added.
        div_num     = {sum_mag, 8'h00} + {24'd0, 1'b0, job_reg.good[15:1]};
        div_den     = job_reg.good;
        div_start   = (state_reg == B_PREP) && (job_reg.op == grbc_pkg::OP_BIAS);
        quot_signed = neg_reg ? (~div_quot + 24'd1) : div_quot;
        // Rate: diff times two plus half of 131, then times the reciprocal of 131.
        rate_num  = {diff_mag, 1'b0} + RNUM_W'(grbc_pkg::SENS_HALF);
        rate_prod = PROD_W'(rate_num_reg) * PROD_W'(grbc_pkg::SENS_RECIP);
        rate_mag  = rate_prod[grbc_pkg::SENS_SHIFT +: 19];
        out_load  = (state_reg == B_OUT) && (!m_valid_reg || m_ready);
    end

    grbc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Sequencer, bias register and result item register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            bias_reg    <= 24'sd0;
            m_valid_reg <= 1'b0;
        end else begin
            // The result item register fills from B_OUT and empties once taken.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_job;
                        state_reg <= B_PREP;
                    end
                end
                B_PREP: begin
                    neg_reg      <= (job_reg.op == grbc_pkg::OP_BIAS) ? job_reg.sum[31]
                                                                      : diff[25];
                    rate_num_reg <= rate_num;
                    rate_reg     <= 19'sd0;
                    state_reg    <= (job_reg.op == grbc_pkg::OP_NONE) ? B_OUT : B_WAIT;
                end
                B_WAIT: begin
                    if (job_reg.op == grbc_pkg::OP_RATE) begin
                        rate_reg  <= neg_reg ? (~rate_mag + 19'd1) : rate_mag;
                        state_reg <= B_OUT;
                    end else if (div_done) begin
                        bias_reg  <= quot_signed;
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        m_rate_q8    <= rate_reg;
                        m_rate_valid <= job_reg.op == grbc_pkg::OP_RATE;
                        m_fail_count <= job_reg.fail_count;
                        m_cal_done   <= job_reg.cal_done;
                        m_cal_ok     <= job_reg.cal_ok;
                        state_reg    <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/gyro_rate_bias_correction.sv */
// Gyro Z rate bias correction, top level: front, job queue and back.
// Items pass the back in the order B_IDLE, B_PREP, B_WAIT, B_OUT: a calibration sample
// that sets a new bias waits in B_WAIT on the 24-step divider, a good measurement gets
// its rate in B_WAIT, and any other item skips B_WAIT. The back takes a new item only back in B_IDLE.
// Reset: synchronous, active low; clears counters, bias and queue, and loads
// cal_samples = 200 and sensor_ready = 0. Depends on grbc_pkg, grbc_front, grbc_queue and grbc_back.
module gyro_rate_bias_correction #(
    parameter int QUEUE_DEPTH = grbc_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // Input item channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [15:0] s_raw_rate,
    input  logic               s_read_ok,
    // Result item channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [18:0] m_rate_q8,
    output logic               m_rate_valid,
    output logic [15:0]        m_fail_count,
    output logic               m_cal_done,
    output logic               m_cal_ok
);

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    grbc_pkg::job_t push_job;
    grbc_pkg::job_t pop_job;

    grbc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_raw_rate (s_raw_rate),
        .s_read_ok  (s_read_ok),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    grbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    grbc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_rate_q8    (m_rate_q8),
        .m_rate_valid (m_rate_valid),
        .m_fail_count (m_fail_count),
        .m_cal_done   (m_cal_done),
        .m_cal_ok     (m_cal_ok)
    );

endmodule
